### src/ammavg_pkg.sv
// Shared widths and sequencer state codes for the magnitude moving average block.
`timescale 1ns / 1ps

package ammavg_pkg;

  // Fixed field widths.
  localparam int unsigned AXIS_W = 16;
  localparam int unsigned MAG_W  = 16;
  // Sum of three squared 16-bit magnitudes stays below 2^32.
  localparam int unsigned SQ_W   = 32;
  // Square root remainder never exceeds twice the partial root.
  localparam int unsigned REM_W  = MAG_W + 1;
  localparam int unsigned ITER_W = 4;
  localparam int unsigned AXIS_SEL_W = 2;

  localparam logic [ITER_W-1:0]     ITER_LAST = ITER_W'(SQ_W / 2 - 1);
  localparam logic [AXIS_SEL_W-1:0] AXIS_X    = 2'd0;
  localparam logic [AXIS_SEL_W-1:0] AXIS_Y    = 2'd1;
  localparam logic [AXIS_SEL_W-1:0] AXIS_Z    = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SQUARE = 4'b0010,
    ST_ROOT   = 4'b0100,
    ST_UPDATE = 4'b1000
  } state_e;

endpackage

### src/ammavg_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module ammavg_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### src/accel_magnitude_moving_average.sv
// Top level: acceleration vector magnitude with a boxcar moving average over a RAM ring.
`timescale 1ns / 1ps

//  Channel | Direction | Handshake                | Word contents
//  --------+-----------+--------------------------+-------------------------------------
//  in      | sink      | in_valid_i / in_ready_o  | accel_x_i, accel_y_i, accel_z_i
//  out     | source    | out_valid_o / out_ready_i| magnitude_o, window_mean_o
//
// Each word has its result in the output register after squaring on one shared 16x16
// multiplier, a one-bit-per-cycle square root, and an update step that updates the
// running sum and writes the ring RAM. A new word is taken only when the sequencer is
// idle, in the cycle after the update, so a word is not accepted before the previous
// one has finished its update.
// After reset the ring reads as zero without a clearing pass: a wrap flag tells whether
// the slot being overwritten has ever been written. The finished result sits in an
// output register, so a stalled output lets the next input word in; only the update
// step waits for that register to drain.

module accel_magnitude_moving_average #(
  parameter int unsigned WINDOW_DEPTH = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [ammavg_pkg::AXIS_W-1:0] accel_x_i,
  input  logic signed [ammavg_pkg::AXIS_W-1:0] accel_y_i,
  input  logic signed [ammavg_pkg::AXIS_W-1:0] accel_z_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [ammavg_pkg::MAG_W-1:0]        magnitude_o,
  output logic [ammavg_pkg::MAG_W-1:0]        window_mean_o
);

  import ammavg_pkg::*;

  // Ring addressing, running sum width and mean shift follow from the window depth.
  localparam int unsigned SLOT_W     = $clog2(WINDOW_DEPTH);
  localparam int unsigned SUM_W      = MAG_W + $clog2(WINDOW_DEPTH);
  // Floor of log2 of the depth, so a depth that is not a power of two still works.
  localparam int unsigned MEAN_SHIFT = $clog2(WINDOW_DEPTH + 1) - 1;
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW_DEPTH - 1);

  state_e state_q, state_d;

  // Absolute axis values, captured at acceptance.
  logic [AXIS_W-1:0] abs_x_q, abs_y_q, abs_z_q;
  logic [AXIS_SEL_W-1:0] axis_q, axis_d;
  logic [ITER_W-1:0]     iter_q, iter_d;

  // Sum of squares; during the root phase it doubles as the radicand shift register.
  logic [SQ_W-1:0]  acc_q, acc_d;
  logic [REM_W-1:0] rem_q, rem_d;
  logic [MAG_W-1:0] root_q, root_d;

  logic [SUM_W-1:0]  sum_q, sum_d;
  logic [SLOT_W-1:0] slot_q, slot_d;
  logic              wrapped_q, wrapped_d;

  logic             out_valid_q, out_valid_d;
  logic [MAG_W-1:0] magnitude_q, magnitude_d;
  logic [MAG_W-1:0] mean_q, mean_d;

  logic in_fire;
  logic upd_fire;

  logic [AXIS_W-1:0] mul_op;
  logic [SQ_W-1:0]   mul_prod;

  logic [REM_W+1:0] cur_rem;
  logic [REM_W+1:0] trial;

  logic [MAG_W-1:0] ring_rdata;
  logic [MAG_W-1:0] old_mag;
  logic [SUM_W-1:0] new_sum;
  logic [SUM_W-1:0] shifted_sum;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  // The result register must be free, or freed this cycle, before the update commits.
  assign upd_fire   = (state_q == ST_UPDATE) && (!out_valid_q || out_ready_i);

  // One shared squaring multiplier, one axis per cycle.
  always_comb begin
    case (axis_q)
      AXIS_X:  mul_op = abs_x_q;
      AXIS_Y:  mul_op = abs_y_q;
      AXIS_Z:  mul_op = abs_z_q;
      default: mul_op = '0;
    endcase
  end

  assign mul_prod = SQ_W'(mul_op) * SQ_W'(mul_op);

  // Restoring square root step: bring down two radicand bits, try 4*root+1.
  assign cur_rem = {rem_q, acc_q[SQ_W-1 -: 2]};
  assign trial   = {1'b0, root_q, 2'b01};

  // A slot never written since reset reads as zero.
  assign old_mag     = wrapped_q ? ring_rdata : '0;
  assign new_sum     = sum_q - SUM_W'(old_mag) + SUM_W'(root_q);
  assign shifted_sum = new_sum >> MEAN_SHIFT;

  always_comb begin
    state_d     = state_q;
    axis_d      = axis_q;
    iter_d      = iter_q;
    acc_d       = acc_q;
    rem_d       = rem_q;
    root_d      = root_q;
    sum_d       = sum_q;
    slot_d      = slot_q;
    wrapped_d   = wrapped_q;
    out_valid_d = out_valid_q;
    magnitude_d = magnitude_q;
    mean_d      = mean_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = ST_SQUARE;
          axis_d  = AXIS_X;
          acc_d   = '0;
          rem_d   = '0;
          root_d  = '0;
          iter_d  = '0;
        end
      end
      ST_SQUARE: begin
        acc_d = acc_q + mul_prod;
        if (axis_q == AXIS_Z) begin
          state_d = ST_ROOT;
        end else begin
          axis_d = axis_q + AXIS_SEL_W'(1);
        end
      end
      ST_ROOT: begin
        acc_d = {acc_q[SQ_W-3:0], 2'b00};
        if (cur_rem >= trial) begin
          rem_d  = REM_W'(cur_rem - trial);
          root_d = {root_q[MAG_W-2:0], 1'b1};
        end else begin
          rem_d  = REM_W'(cur_rem);
          root_d = {root_q[MAG_W-2:0], 1'b0};
        end
        if (iter_q == ITER_LAST) begin
          state_d = ST_UPDATE;
        end else begin
          iter_d = iter_q + ITER_W'(1);
        end
      end
      ST_UPDATE: begin
        if (upd_fire) begin
          sum_d       = new_sum;
          out_valid_d = 1'b1;
          magnitude_d = root_q;
          mean_d      = (|shifted_sum[SUM_W-1:MAG_W]) ? '1 : shifted_sum[MAG_W-1:0];
          if (slot_q == SLOT_LAST) begin
            slot_d    = '0;
            wrapped_d = 1'b1;
          end else begin
            slot_d = slot_q + SLOT_W'(1);
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      axis_q      <= AXIS_X;
      iter_q      <= '0;
      sum_q       <= '0;
      slot_q      <= '0;
      wrapped_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      axis_q      <= axis_d;
      iter_q      <= iter_d;
      sum_q       <= sum_d;
      slot_q      <= slot_d;
      wrapped_q   <= wrapped_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      abs_x_q <= accel_x_i[AXIS_W-1] ? AXIS_W'(-accel_x_i) : AXIS_W'(accel_x_i);
      abs_y_q <= accel_y_i[AXIS_W-1] ? AXIS_W'(-accel_y_i) : AXIS_W'(accel_y_i);
      abs_z_q <= accel_z_i[AXIS_W-1] ? AXIS_W'(-accel_z_i) : AXIS_W'(accel_z_i);
    end
    acc_q       <= acc_d;
    rem_q       <= rem_d;
    root_q      <= root_d;
    magnitude_q <= magnitude_d;
    mean_q      <= mean_d;
  end

  // The slot to be overwritten is read at acceptance; its data waits in the RAM
  // output register until the update step, and nothing else reads the ring.
  ammavg_ram #(
    .WIDTH (MAG_W),
    .DEPTH (WINDOW_DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (upd_fire),
    .waddr_i (slot_q),
    .wdata_i (root_q),
    .re_i    (in_fire),
    .raddr_i (slot_q),
    .rdata_o (ring_rdata)
  );

  assign out_valid_o   = out_valid_q;
  assign magnitude_o   = magnitude_q;
  assign window_mean_o = mean_q;

  // An accepted word always starts squaring at the x axis.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q == ST_SQUARE) && (axis_q == AXIS_X))
    else $error("squaring did not start after an accepted word");

  // The root phase ends after exactly its last iteration.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ROOT) && (iter_q == ITER_LAST) |=> (state_q == ST_UPDATE))
    else $error("square root phase did not hand over to the update step");

  // The write slot never leaves the window.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    slot_q <= SLOT_LAST)
    else $error("write slot outside the ring");

  // A pending result is never overwritten by the update step.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    upd_fire |-> (!out_valid_q || out_ready_i))
    else $error("update step overwrote a pending result");

endmodule

### sim/testbench.sv
// Self-checking testbench for the acceleration magnitude moving average block.
`timescale 1ns / 1ps

module testbench;
  import ammavg_pkg::*;

  // Window depth of the block under test, and the mean shift that goes with it:
  // floor(log2(depth)), which also holds for a depth that is not a power of two.
  localparam int unsigned DEPTH       = 64;
  localparam int unsigned MEAN_SHIFT  = $clog2(DEPTH + 1) - 1;

  localparam int unsigned IDLE_PCT    = 38;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned DRAIN_WAIT  = 30;
  localparam int unsigned REPORT_MAX  = 10;
  localparam int unsigned NUM_CORNERS = 20;
  // Well above the slowest legal run of about 2000 words, stalls included.
  localparam longint      TIMEOUT_NS  = 5_000_000;

  typedef logic signed [AXIS_W-1:0] axis_t;

  typedef struct packed {
    logic [MAG_W-1:0] magnitude;
    logic [MAG_W-1:0] window_mean;
  } motion_result_t;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  axis_t       accel_x_i   = '0;
  axis_t       accel_y_i   = '0;
  axis_t       accel_z_i   = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [MAG_W-1:0] magnitude_o;
  logic [MAG_W-1:0] window_mean_o;

  // Shadow of the block's state: the magnitude ring, its exact sum and the next slot.
  logic [MAG_W-1:0] shadow_ring [DEPTH];
  int unsigned      shadow_sum;
  int unsigned      shadow_slot;

  motion_result_t   expected_results [$];

  int unsigned words_sent;
  int unsigned results_checked;
  int unsigned mismatch_count;
  int unsigned input_stall_cycles;

  // Idling switches, flipped by the test tasks.
  bit          send_idle_on = 1'b0;
  bit          recv_idle_on = 1'b0;
  int unsigned hold_requests = 0;
  int unsigned hold_served;
  int unsigned hold_left;

  accel_magnitude_moving_average #(
    .WINDOW_DEPTH(DEPTH)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .accel_x_i    (accel_x_i),
    .accel_y_i    (accel_y_i),
    .accel_z_i    (accel_z_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .magnitude_o  (magnitude_o),
    .window_mean_o(window_mean_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Floor square root, one result bit per pass, on the 32-bit sum of squares.
  function automatic logic [MAG_W-1:0] floor_root(input logic [31:0] radicand);
    logic [31:0] remainder;
    logic [31:0] root;
    logic [31:0] probe;
    int          i;
    remainder = radicand;
    root      = '0;
    probe     = 32'h4000_0000;
    for (i = 0; i < 16; i++) begin
      if (remainder >= root + probe) begin
        remainder = remainder - (root + probe);
        root      = (root >> 1) + probe;
      end else begin
        root = root >> 1;
      end
      probe = probe >> 2;
    end
    return root[MAG_W-1:0];
  endfunction

  // Advances the shadow state by one sample and returns the word the block must give.
  function automatic motion_result_t predict_motion(input axis_t x, input axis_t y,
                                                    input axis_t z);
    longint         sx;
    longint         sy;
    longint         sz;
    logic [31:0]    sum_sq;
    motion_result_t res;
    int unsigned    mean_full;
    sx        = longint'(x);
    sy        = longint'(y);
    sz        = longint'(z);
    sum_sq    = 32'(sx * sx + sy * sy + sz * sz);
    res.magnitude = floor_root(sum_sq);
    if (shadow_slot >= DEPTH) begin
      shadow_slot = 0;
    end
    shadow_sum = shadow_sum - shadow_ring[shadow_slot] + res.magnitude;
    shadow_ring[shadow_slot] = res.magnitude;
    shadow_slot = (shadow_slot + 1 >= DEPTH) ? 0 : shadow_slot + 1;
    mean_full = shadow_sum >> MEAN_SHIFT;
    res.window_mean = (mean_full > 32'hFFFF) ? MAG_W'(16'hFFFF) : mean_full[MAG_W-1:0];
    return res;
  endfunction

  // Offers one sample, waits for the handshake, records the expectation, and then
  // idles the input for a random number of cycles when idling is on.
  task automatic send_sample(input axis_t x, input axis_t y, input axis_t z);
    in_valid_i <= 1'b1;
    accel_x_i  <= x;
    accel_y_i  <= y;
    accel_z_i  <= z;
    do @(posedge clk_i); while (!in_ready_o);
    expected_results.push_back(predict_motion(x, y, z));
    words_sent++;
    while (send_idle_on && $urandom_range(99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  function automatic axis_t pick_extreme();
    case ($urandom_range(5))
      0:       return axis_t'(-32768);
      1:       return axis_t'(-32767);
      2:       return axis_t'(-1);
      3:       return axis_t'(0);
      4:       return axis_t'(1);
      default: return axis_t'(32767);
    endcase
  endfunction

  // Mix of full-range noise, extreme codes, small vectors and a sensor lying
  // near rest with one axis carrying about one g.
  task automatic send_random_sample();
    int unsigned mode;
    int unsigned heavy_axis;
    axis_t       ax [3];
    mode = $urandom_range(99);
    if (mode < 40) begin
      foreach (ax[k]) ax[k] = axis_t'($urandom());
    end else if (mode < 55) begin
      foreach (ax[k]) ax[k] = pick_extreme();
    end else if (mode < 75) begin
      foreach (ax[k]) ax[k] = axis_t'($urandom_range(511)) - axis_t'(256);
    end else begin
      foreach (ax[k]) ax[k] = axis_t'($urandom_range(600)) - axis_t'(300);
      heavy_axis = $urandom_range(2);
      ax[heavy_axis] = ax[heavy_axis] + ($urandom_range(1) ? axis_t'(4096) : axis_t'(-4096));
    end
    send_sample(ax[0], ax[1], ax[2]);
  endtask

  // Hand-picked vectors while the window is still filling: zero, all-negative and
  // all-positive full scale, single axes, exact Pythagorean triples and one g.
  task automatic test_corner_samples();
    axis_t cx [NUM_CORNERS] = '{0, -32768, 32767, -32768, 0, 0, 32767, 3, 3, -1,
                                1, 0, 4096, -4096, 2, 32767, 0, -1, 255, 16384};
    axis_t cy [NUM_CORNERS] = '{0, -32768, 32767, 0, -32768, 0, -32768, 4, 4, -1,
                                0, 0, 4096, 0, 2, 0, 32767, 0, -256, -16384};
    axis_t cz [NUM_CORNERS] = '{0, -32768, 32767, 0, 0, -32768, 32767, 0, 12, -1,
                                0, 4096, 4096, 0, 1, 0, -32768, 0, 128, 16384};
    send_idle_on = 1'b0;
    recv_idle_on = 1'b0;
    foreach (cx[k]) send_sample(cx[k], cy[k], cz[k]);
  endtask

  // Back-to-back words on both sides, which wraps the ring several times.
  task automatic test_steady_stream();
    send_idle_on = 1'b0;
    recv_idle_on = 1'b0;
    repeat (300) send_random_sample();
  endtask

  // Random gaps on the input and random stalls on the output.
  task automatic test_random_samples();
    send_idle_on = 1'b1;
    recv_idle_on = 1'b1;
    repeat (1430) send_random_sample();
  endtask

  // The output is held off for a long stretch while words keep coming, so the
  // result register fills and the block has to refuse input.
  task automatic test_output_backpressure();
    send_idle_on = 1'b0;
    recv_idle_on = 1'b1;
    hold_requests++;
    repeat (200) send_random_sample();
  endtask

  // Output side: ready with random stalls, plus the long hold-off on request.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      hold_served <= 0;
      hold_left   <= 0;
    end else if (hold_requests != hold_served) begin
      hold_served <= hold_requests;
      hold_left   <= HOLD_CYCLES;
      out_ready_i <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else if (recv_idle_on) begin
      out_ready_i <= ($urandom_range(99) >= IDLE_PCT);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Compares every accepted result word with the oldest expectation.
  always @(posedge clk_i) begin
    motion_result_t want;
    if (rst_ni && in_valid_i && !in_ready_o) begin
      input_stall_cycles++;
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX) begin
          $display("ERROR: result with nothing expected: magnitude %0d mean %0d",
                   magnitude_o, window_mean_o);
        end
      end else begin
        want = expected_results.pop_front();
        results_checked++;
        if (magnitude_o !== want.magnitude || window_mean_o !== want.window_mean) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_MAX) begin
            $display("ERROR: result %0d: magnitude %0d (expected %0d), mean %0d (expected %0d)",
                     results_checked, magnitude_o, want.magnitude,
                     window_mean_o, want.window_mean);
          end
        end
      end
    end
  end

  initial begin
    foreach (shadow_ring[k]) shadow_ring[k] = '0;
    shadow_sum         = 0;
    shadow_slot        = 0;
    words_sent         = 0;
    results_checked    = 0;
    mismatch_count     = 0;
    input_stall_cycles = 0;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_corner_samples();
    test_steady_stream();
    test_random_samples();
    test_output_backpressure();
    in_valid_i <= 1'b0;

    // Let the last words come out, then watch for stray results.
    recv_idle_on = 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    if (expected_results.size() != 0) begin
      mismatch_count += expected_results.size();
    end
    $display("Sent %0d samples and checked %0d results (%0d mismatches).",
             words_sent, results_checked, mismatch_count);
    $display("Covered corner vectors, many ring wraps, random idling and %0d stalled input cycles.",
             input_stall_cycles);
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Timeout with %0d results still expected.", expected_results.size());
    $display("DONE: errors detected");
    $finish;
  end

endmodule
